FILE: rtl/core/dtps_pkg.sv
package dtps_pkg;

    localparam int DEF_STORE_DEPTH   = 4096;
    localparam int DEF_WINDOW_LENGTH = 2048;
    localparam int DEF_SAMPLE_BITS   = 24;

    localparam int STEP_BITS     = 19;
    localparam int FRAC_BITS     = 16;
    localparam int GAIN_BITS     = FRAC_BITS + 1;
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 32;

    // register select is the word index taken from paddr
    localparam logic REG_DELAY_STEP    = 1'b0;
    localparam logic REG_STEREO_ENABLE = 1'b1;

    typedef struct packed {
        logic in_take;
        logic clr_wr;
        logic tap;
        logic rd_lo;
        logic rd_hi;
        logic s0_ld;
        logic mul_ld;
        logic int_ld;
        logic gain_ld;
        logic acc_ld;
        logic acc_first;
        logic out_ld;
    } ctrl_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic sweep_last;
        logic out_free;
    } ctrl_sts_t;

endpackage

FILE: rtl/core/dtps_if.sv
interface dtps_in_if import dtps_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

interface dtps_out_if import dtps_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

FILE: rtl/core/dtps_ram.sv
module dtps_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/dtps_regs.sv
module dtps_regs import dtps_pkg::*; (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic        [CFG_ADDR_BITS-1:0] paddr,
    input  logic        [CFG_DATA_BITS-1:0] pwdata,
    output logic        [CFG_DATA_BITS-1:0] prdata,
    output logic                            pready,
    output logic signed [STEP_BITS-1:0]     delay_step,
    output logic                            stereo_enable
);

    logic signed [STEP_BITS-1:0] delay_step_reg;
    logic                        stereo_enable_reg;
    logic                        reg_sel;
    logic                        wr_en;

    assign reg_sel = paddr[CFG_ADDR_BITS-1];
    assign wr_en   = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_step_reg    <= '0;
            stereo_enable_reg <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (reg_sel)
                REG_DELAY_STEP:    delay_step_reg    <= pwdata[STEP_BITS-1:0];
                REG_STEREO_ENABLE: stereo_enable_reg <= pwdata[0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_sel)
            REG_DELAY_STEP:
                prdata = {{(CFG_DATA_BITS-STEP_BITS){delay_step_reg[STEP_BITS-1]}},
                          delay_step_reg};
            REG_STEREO_ENABLE:
                prdata = {{(CFG_DATA_BITS-1){1'b0}}, stereo_enable_reg};
            default:
                prdata = '0;
        endcase
    end

    assign delay_step    = delay_step_reg;
    assign stereo_enable = stereo_enable_reg;

endmodule

FILE: rtl/core/dtps_ctrl.sv
module dtps_ctrl import dtps_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  ctrl_sts_t sts,
    output ctrl_cmd_t cmd
);

    localparam logic [3:0] S_CLEAR = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_RD0   = 4'd2;
    localparam logic [3:0] S_RD1   = 4'd3;
    localparam logic [3:0] S_MUL1  = 4'd4;
    localparam logic [3:0] S_INT   = 4'd5;
    localparam logic [3:0] S_MUL2  = 4'd6;
    localparam logic [3:0] S_ACC   = 4'd7;
    localparam logic [3:0] S_OUT   = 4'd8;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       tap_reg;
    logic       tap_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            tap_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tap_reg   <= tap_next;
        end
    end

    always_comb
    begin
        cmd        = '0;
        cmd.tap    = tap_reg;
        state_next = state_reg;
        tap_next   = tap_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr_wr = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                cmd.in_take = 1'b1;
                tap_next    = 1'b0;
                if (sts.in_valid)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:
            begin
                cmd.rd_lo  = 1'b1;
                state_next = S_RD1;
            end
            S_RD1:
            begin
                cmd.rd_hi  = 1'b1;
                cmd.s0_ld  = 1'b1;
                state_next = S_MUL1;
            end
            S_MUL1:
            begin
                cmd.mul_ld = 1'b1;
                state_next = S_INT;
            end
            S_INT:
            begin
                cmd.int_ld = 1'b1;
                state_next = S_MUL2;
            end
            S_MUL2:
            begin
                cmd.gain_ld = 1'b1;
                state_next  = S_ACC;
            end
            S_ACC:
            begin
                cmd.acc_ld    = 1'b1;
                cmd.acc_first = ~tap_reg;
                if (tap_reg)
                begin
                    state_next = S_OUT;
                end
                else
                begin
                    tap_next   = 1'b1;
                    state_next = S_RD0;
                end
            end
            S_OUT:
            begin
                // hold until the output register can take the item
                if (sts.out_free)
                begin
                    cmd.out_ld = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/core/dtps_lane.sv
module dtps_lane import dtps_pkg::*; #(
    parameter int STORE_DEPTH = DEF_STORE_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                            clk,
    input  ctrl_cmd_t                       cmd,
    input  logic                            we,
    input  logic [$clog2(STORE_DEPTH)-1:0]  waddr,
    input  logic [SAMPLE_BITS-1:0]          wdata,
    input  logic [$clog2(STORE_DEPTH)-1:0]  raddr,
    input  logic [FRAC_BITS-1:0]            frac,
    input  logic [GAIN_BITS-1:0]            gain,
    output logic signed [SAMPLE_BITS-1:0]   result
);

    localparam int TAP_BITS   = SAMPLE_BITS + FRAC_BITS;
    localparam int PROD_BITS  = SAMPLE_BITS + FRAC_BITS + 2;
    localparam int GPROD_BITS = TAP_BITS + GAIN_BITS + 1;
    localparam int RND_BITS   = TAP_BITS + 2;
    localparam logic [RND_BITS-1:0] HALF = RND_BITS'(1) << (FRAC_BITS - 1);

    logic        [SAMPLE_BITS-1:0] rdata;
    logic signed [SAMPLE_BITS-1:0] s0_reg;
    logic signed [SAMPLE_BITS:0]   diff;
    logic signed [PROD_BITS-1:0]   prod_next;
    logic signed [PROD_BITS-1:0]   prod_reg;
    logic signed [PROD_BITS-1:0]   interp_full;
    logic signed [TAP_BITS-1:0]    interp_reg;
    logic signed [GPROD_BITS-1:0]  gprod_next;
    logic signed [GPROD_BITS-1:0]  gprod_reg;
    logic signed [TAP_BITS-1:0]    tap_scaled;
    logic signed [TAP_BITS:0]      acc_next;
    logic signed [TAP_BITS:0]      acc_reg;
    logic        [RND_BITS-1:0]    rnd_sum;
    logic        [SAMPLE_BITS+1:0] rnd;

    dtps_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    // s0 + frac * (s1 - s0), then weight by the tap gain
    assign diff        = $signed({rdata[SAMPLE_BITS-1], rdata})
                       - $signed({s0_reg[SAMPLE_BITS-1], s0_reg});
    assign prod_next   = diff * $signed({1'b0, frac});
    assign interp_full = $signed({{2{s0_reg[SAMPLE_BITS-1]}}, s0_reg, {FRAC_BITS{1'b0}}})
                       + prod_reg;
    assign gprod_next  = interp_reg * $signed({1'b0, gain});
    assign tap_scaled  = gprod_reg[TAP_BITS+FRAC_BITS-1:FRAC_BITS];
    assign acc_next    = (cmd.acc_first ? '0 : acc_reg)
                       + $signed({tap_scaled[TAP_BITS-1], tap_scaled});

    always_ff @(posedge clk)
    begin
        if (cmd.s0_ld)
        begin
            s0_reg <= rdata;
        end
        if (cmd.mul_ld)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.int_ld)
        begin
            interp_reg <= interp_full[TAP_BITS-1:0];
        end
        if (cmd.gain_ld)
        begin
            gprod_reg <= gprod_next;
        end
        if (cmd.acc_ld)
        begin
            acc_reg <= acc_next;
        end
    end

    // round half up, drop the fraction, then saturate
    assign rnd_sum = {acc_reg[TAP_BITS], acc_reg} + HALF;
    assign rnd     = rnd_sum[RND_BITS-1:FRAC_BITS];

    always_comb
    begin
        if ((rnd[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b000)
            || (rnd[SAMPLE_BITS+1:SAMPLE_BITS-1] == 3'b111))
        begin
            result = rnd[SAMPLE_BITS-1:0];
        end
        else
        begin
            result = {rnd[SAMPLE_BITS+1], {(SAMPLE_BITS-1){~rnd[SAMPLE_BITS+1]}}};
        end
    end

endmodule

FILE: rtl/core/dtps_dp.sv
module dtps_dp import dtps_pkg::*; #(
    parameter int STORE_DEPTH   = DEF_STORE_DEPTH,
    parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ctrl_cmd_t                     cmd,
    output ctrl_sts_t                     sts,
    input  logic signed [STEP_BITS-1:0]   delay_step,
    input  logic                          stereo_enable,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_in,
    input  logic signed [SAMPLE_BITS-1:0] right_in,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);

    localparam int ADDR_BITS = $clog2(STORE_DEPTH);
    localparam int WIN_BITS  = $clog2(WINDOW_LENGTH);
    localparam int PH_BITS   = WIN_BITS + FRAC_BITS;
    localparam int POS_BITS  = ADDR_BITS + FRAC_BITS;

    logic                          accept;
    logic [ADDR_BITS-1:0]          wi_reg;
    logic [PH_BITS-1:0]            phase_reg;
    logic [PH_BITS-1:0]            phase_next;
    logic [PH_BITS-1:0]            step_ext;
    logic [PH_BITS-1:0]            d_tap;
    logic [PH_BITS:0]              d_mirror;
    logic [GAIN_BITS-1:0]          gain;
    logic [POS_BITS-1:0]           pos;
    logic [ADDR_BITS-1:0]          i0_reg;
    logic [FRAC_BITS-1:0]          f_reg;
    logic [GAIN_BITS-1:0]          gain_reg;
    logic [ADDR_BITS-1:0]          raddr;
    logic                          we_left;
    logic                          we_right;
    logic [SAMPLE_BITS-1:0]        wdata_left;
    logic [SAMPLE_BITS-1:0]        wdata_right;
    logic signed [SAMPLE_BITS-1:0] res_left;
    logic signed [SAMPLE_BITS-1:0] res_right;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;

    assign accept   = cmd.in_take & in_valid;
    assign in_ready = cmd.in_take;

    // window length is a power of two, so the wrap is the natural carry-out
    assign step_ext   = {{(PH_BITS-STEP_BITS){delay_step[STEP_BITS-1]}}, delay_step};
    assign phase_next = phase_reg + step_ext;

    // second tap sits half a window away: flip the top phase bit
    assign d_tap    = cmd.tap ? {~phase_reg[PH_BITS-1], phase_reg[PH_BITS-2:0]} : phase_reg;
    assign d_mirror = {1'b1, {PH_BITS{1'b0}}} - {1'b0, d_tap};
    assign gain     = d_tap[PH_BITS-1] ? GAIN_BITS'(d_mirror >> (WIN_BITS - 1))
                                       : GAIN_BITS'(d_tap >> (WIN_BITS - 1));
    assign pos      = {wi_reg, {FRAC_BITS{1'b0}}} - POS_BITS'(d_tap);
    assign raddr    = cmd.rd_hi ? (i0_reg + ADDR_BITS'(1)) : pos[POS_BITS-1:FRAC_BITS];

    assign we_left     = cmd.clr_wr | accept;
    assign we_right    = cmd.clr_wr | (accept & stereo_enable);
    assign wdata_left  = cmd.clr_wr ? '0 : left_in;
    assign wdata_right = cmd.clr_wr ? '0 : right_in;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg        <= '0;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr_wr || cmd.out_ld)
            begin
                wi_reg <= wi_reg + ADDR_BITS'(1);
            end
            if (accept)
            begin
                phase_reg <= phase_next;
            end
            if (cmd.out_ld)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_lo)
        begin
            i0_reg   <= pos[POS_BITS-1:FRAC_BITS];
            f_reg    <= pos[FRAC_BITS-1:0];
            gain_reg <= gain;
        end
        if (cmd.out_ld)
        begin
            left_out_reg  <= res_left;
            right_out_reg <= stereo_enable ? res_right : res_left;
        end
    end

    dtps_lane #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_left (
        .clk    (clk),
        .cmd    (cmd),
        .we     (we_left),
        .waddr  (wi_reg),
        .wdata  (wdata_left),
        .raddr  (raddr),
        .frac   (f_reg),
        .gain   (gain_reg),
        .result (res_left)
    );

    dtps_lane #(
        .STORE_DEPTH (STORE_DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_lane_right (
        .clk    (clk),
        .cmd    (cmd),
        .we     (we_right),
        .waddr  (wi_reg),
        .wdata  (wdata_right),
        .raddr  (raddr),
        .frac   (f_reg),
        .gain   (gain_reg),
        .result (res_right)
    );

    assign sts.in_valid   = in_valid;
    assign sts.sweep_last = &wi_reg;
    assign sts.out_free   = ~out_valid_reg | out_ready;

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

endmodule

FILE: rtl/core/dual_tap_delay_pitch_shifter_top.sv
// Dual-tap delay-line pitch shifter. Each item is one stereo sample pair; both
// samples go into their own circular store, and two taps half a window apart
// read back with linear interpolation, weighted by a triangular crossfade gain,
// summed, rounded and saturated. delay_step (APB word 0) sets one minus the
// pitch ratio with 16 fraction bits; stereo_enable (word 1) at 0 copies the left
// result to the right and leaves the right store untouched. STORE_DEPTH and
// WINDOW_LENGTH must be powers of two. After reset the block sweeps both stores
// to zero, one entry per cycle, over all STORE_DEPTH entries (4096 by default)
// and accepts no item during that time; APB writes are taken throughout. An
// item then runs through both taps in turn, and its result is loaded into the
// output register once that register is free; only then does the input become
// ready again, so no new item is taken before the last one is through. The pace
// is set by the single read port of each store: the four samples of the two
// taps are fetched one after another, each tap running through a read,
// interpolate-multiply and gain-multiply sequence.
module dual_tap_delay_pitch_shifter_top import dtps_pkg::*; #(
    parameter int STORE_DEPTH   = DEF_STORE_DEPTH,
    parameter int WINDOW_LENGTH = DEF_WINDOW_LENGTH,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS
) (
    input  logic                     clk,
    input  logic                     rst_n,
    dtps_in_if.sink                  in_ch,
    dtps_out_if.source               out_ch,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [CFG_DATA_BITS-1:0] pwdata,
    output logic [CFG_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    ctrl_cmd_t                   cmd;
    ctrl_sts_t                   sts;
    logic signed [STEP_BITS-1:0] delay_step;
    logic                        stereo_enable;

    dtps_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .delay_step    (delay_step),
        .stereo_enable (stereo_enable)
    );

    dtps_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    dtps_dp #(
        .STORE_DEPTH   (STORE_DEPTH),
        .WINDOW_LENGTH (WINDOW_LENGTH),
        .SAMPLE_BITS   (SAMPLE_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .delay_step    (delay_step),
        .stereo_enable (stereo_enable),
        .in_valid      (in_ch.valid),
        .in_ready      (in_ch.ready),
        .left_in       (in_ch.left_in),
        .right_in      (in_ch.right_in),
        .out_valid     (out_ch.valid),
        .out_ready     (out_ch.ready),
        .left_out      (out_ch.left_out),
        .right_out     (out_ch.right_out)
    );

endmodule

FILE: rtl/core/dtps_checker.sv
module dtps_checker import dtps_pkg::*; #(
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] left_out,
    input logic [SAMPLE_BITS-1:0] right_out
);

    // one item in flight: an accepted item closes the input side
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input ready right after an accepted item");

    // store sweep runs first after reset
    a_sweep_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !in_ready)
        else $error("input ready before the store sweep");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> ($stable(left_out) && $stable(right_out)))
        else $error("result changed while stalled");

endmodule

bind dual_tap_delay_pitch_shifter_top dtps_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_dtps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .left_out  (out_ch.left_out),
    .right_out (out_ch.right_out)
);
